// ===== src/mnc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mnc_pkg
// Shared codes, field widths, defaults and the decode bundle for the
// neighbour count sampler.
// ----------------------------------------------------------------------------
package mnc_pkg;

   // Default values for the top-level parameters.
   localparam int MAX_TILES_DEF   = 16;
   localparam int RADIUS_DEF      = 1;
   localparam int COUNT_WIDTH_DEF = 16;

   // Fixed field widths of the request and response transactions.
   localparam int TILE_W   = 4;
   localparam int OFFSET_W = 3;
   localparam int RND_W    = 31;
   localparam int CFG_W    = 5;
   localparam int OUT_W    = 16;
   localparam int OUT_MAX  = 65535;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_OBSERVE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_IGNORE  = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_TILE   = 2'd2;

   // Outcome of request decoding: run says the table must be accessed,
   // status is the code returned when it is not.
   typedef struct packed {
      logic                run;
      logic [STATUS_W-1:0] status;
   } mnc_dec_type;

endpackage : mnc_pkg
`default_nettype wire

// ===== src/markov_neighbour_count_sampler.sv =====
// Observe and query results pass through the read, update and posting states to the response register.
// Sample: a draw makes two passes over the row through the single table read port,
// with the bit-serial remainder unit between them.
// One transaction is in work at a time; a finished response may wait while the next is taken.
// Reset is synchronous; afterwards a clearing pass zeroes the table, one entry per cycle,
// while requests are stalled.
`default_nettype none
// ----------------------------------------------------------------------------
// markov_neighbour_count_sampler
// Saturating transition count table indexed by neighbour offset, centre tile
// and neighbour tile, with observe, query and weighted sample requests.
// ----------------------------------------------------------------------------
module markov_neighbour_count_sampler
   import mnc_pkg::*;
#(
   parameter int MAX_TILES   = MAX_TILES_DEF,
   parameter int RADIUS      = RADIUS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration port.
   input  logic                       csr_write,
   input  logic [CFG_W-1:0]           csr_tiles_in_use,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [REQ_W-1:0]           req_type,
   input  logic signed [OFFSET_W-1:0] req_offset_x,
   input  logic signed [OFFSET_W-1:0] req_offset_y,
   input  logic [TILE_W-1:0]          req_current_tile,
   input  logic [TILE_W-1:0]          req_other_tile,
   input  logic [RND_W-1:0]           req_random_value,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [TILE_W-1:0]          rsp_tile_out,
   output logic [OUT_W-1:0]           rsp_count_out,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int SIDE        = 2 * RADIUS + 1;
   localparam int NUM_OFFSETS = SIDE * SIDE - 1;
   localparam int DEPTH       = NUM_OFFSETS * MAX_TILES * MAX_TILES;
   localparam int ADDR_W      = $clog2(DEPTH);
   // A row total covers at most 2**TILE_W counts.
   localparam int SUM_W       = COUNT_WIDTH + TILE_W;
   localparam int CLIP_W      = (SUM_W > OUT_W) ? SUM_W : OUT_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_SUM    = 3'd4;
   localparam logic [2:0] S_MOD    = 3'd5;
   localparam logic [2:0] S_WALK   = 3'd6;
   localparam logic [2:0] S_POST   = 3'd7;

   // Response counts saturate at the width of the count_out field.
   function automatic logic [OUT_W-1:0] clip_count(input logic [SUM_W-1:0] v);
      logic [CLIP_W-1:0] w;
      w = CLIP_W'(v);
      return (w > CLIP_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(w);
   endfunction

   // The count table. Reads are registered, so data arrives in the cycle
   // after the address is presented.
   logic [COUNT_WIDTH-1:0] table_mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rdata_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [ADDR_W-1:0]      mem_raddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   logic [2:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [CFG_W-1:0]       tiles_ff;
   logic [REQ_W-1:0]       req_ff, req_in;
   logic [ADDR_W-1:0]      row_ff, row_in;
   logic [TILE_W-1:0]      oth_ff, oth_in;
   logic [RND_W-1:0]       rnd_ff, rnd_in;
   logic [CFG_W-1:0]       issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [TILE_W-1:0]      dtile_ff, dtile_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [SUM_W-1:0]       run_ff, run_in;
   logic [SUM_W-1:0]       r_ff, r_in;
   logic [TILE_W-1:0]      res_tile_ff, res_tile_in;
   logic [OUT_W-1:0]       res_count_ff, res_count_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TILE_W-1:0]      rsp_tile_ff, rsp_tile_in;
   logic [OUT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [CFG_W-1:0]       ntiles;
   mnc_dec_type            dec;
   logic [ADDR_W-1:0]      dec_row;
   logic                   req_accept;
   logic                   rsp_load;
   logic                   mod_start;
   logic                   mod_done;
   logic [SUM_W-1:0]       mod_rem;
   logic [COUNT_WIDTH-1:0] bumped;
   logic [SUM_W-1:0]       run_sum;

   // A tiles_in_use value above the table size behaves as the table size.
   assign ntiles = (int'(tiles_ff) > MAX_TILES) ? CFG_W'(MAX_TILES) : tiles_ff;

   // Requests are taken only in the idle state, which also covers the
   // clearing pass after reset.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   mnc_decode #(
      .MAX_TILES (MAX_TILES),
      .RADIUS    (RADIUS),
      .ADDR_W    (ADDR_W)
   ) u_decode (
      .req_type     (1'b1),
      .req_code     (req_type),
      .offset_x     (req_offset_x),
      .offset_y     (req_offset_y),
      .current_tile (req_current_tile),
      .other_tile   (req_other_tile),
      .ntiles       (ntiles),
      .dec          (dec),
      .row_addr     (dec_row)
   );

   mnc_mod_unit #(
      .SUM_W (SUM_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (total_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Saturating increment of the count read for an observe transaction.
   assign bumped  = (rdata_ff == '1) ? rdata_ff : rdata_ff + 1'b1;
   // Running sum of the sample walk including the count that just arrived.
   assign run_sum = run_ff + SUM_W'(rdata_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      row_in        = row_ff;
      oth_in        = oth_ff;
      rnd_in        = rnd_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      dtile_in      = dtile_ff;
      total_in      = total_ff;
      run_in        = run_ff;
      r_in          = r_ff;
      res_tile_in   = res_tile_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = row_ff + ADDR_W'(issue_ff[TILE_W-1:0]);
      mod_start     = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // Zero one table entry per cycle.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               req_in        = req_type;
               row_in        = dec_row;
               oth_in        = req_other_tile;
               rnd_in        = req_random_value;
               issue_in      = '0;
               pend_in       = 1'b0;
               total_in      = '0;
               res_tile_in   = '0;
               res_count_in  = '0;
               res_status_in = dec.status;
               if (!dec.run) begin
                  // Rejected or ignored transactions answer at once.
                  state_in = S_POST;
               end else if (req_type == REQ_SAMPLE) begin
                  state_in = S_SUM;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         S_READ: begin
            mem_re    = 1'b1;
            mem_raddr = row_ff + ADDR_W'(oth_ff);
            state_in  = S_UPDATE;
         end

         S_UPDATE: begin
            // The write lands before any later read, since the next
            // transaction cannot be accepted until this one is posted.
            if (req_ff == REQ_OBSERVE) begin
               mem_we       = 1'b1;
               mem_waddr    = row_ff + ADDR_W'(oth_ff);
               mem_wdata    = bumped;
               res_count_in = clip_count(SUM_W'(bumped));
            end else begin
               res_count_in = clip_count(SUM_W'(rdata_ff));
            end
            state_in = S_POST;
         end

         S_SUM: begin
            // First pass over the row: one read issued per cycle, the
            // data accumulated in the cycle after.
            if (issue_ff < ntiles) begin
               mem_re   = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
               dtile_in = issue_ff[TILE_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               total_in = total_ff + SUM_W'(rdata_ff);
            end
            if ((issue_ff == ntiles) && !pend_ff) begin
               res_count_in = clip_count(total_ff);
               if (total_ff == '0) begin
                  // Empty row: tile 0 with a zero count.
                  state_in = S_POST;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end

         S_MOD: begin
            if (mod_done) begin
               r_in     = mod_rem;
               issue_in = '0;
               pend_in  = 1'b0;
               run_in   = '0;
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            // Second pass: the first tile whose running sum exceeds the
            // reduced draw is the sample. The remainder is below the row
            // total, so a tile is always found.
            if (issue_ff < ntiles) begin
               mem_re   = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
               dtile_in = issue_ff[TILE_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               run_in = run_sum;
               if (run_sum > r_ff) begin
                  res_tile_in = dtile_ff;
                  pend_in     = 1'b0;
                  state_in    = S_POST;
               end
            end else if (issue_ff == ntiles) begin
               state_in = S_POST;
            end
         end

         S_POST: begin
            // Move the result into the response register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Response register: holds a transaction until the receiver takes it.
   always_comb begin
      rsp_tile_in   = rsp_tile_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_tile_in   = res_tile_ff;
         rsp_count_in  = res_count_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= table_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         tiles_ff     <= CFG_W'(16);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            tiles_ff <= csr_tiles_in_use;
         end
      end
      req_ff        <= req_in;
      row_ff        <= row_in;
      oth_ff        <= oth_in;
      rnd_ff        <= rnd_in;
      issue_ff      <= issue_in;
      dtile_ff      <= dtile_in;
      total_ff      <= total_in;
      run_ff        <= run_in;
      r_ff          <= r_in;
      res_tile_ff   <= res_tile_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_tile_ff   <= rsp_tile_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tile_out  = rsp_tile_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

   // Only the clearing pass and the observe update may write the table.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_CLEAR) || (state_ff == S_UPDATE)))
      else $error("table written outside clear or update");

   // The reduced draw must lie below the row total during the walk.
   a_draw_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (r_ff < total_ff))
      else $error("remainder not below row total");

   // Row reads never run past the tiles in use.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SUM) || (state_ff == S_WALK)) |-> (issue_ff <= ntiles))
      else $error("row read index past tiles in use");

   // The remainder unit finishes only while the sequencer waits for it.
   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == S_MOD))
      else $error("remainder done outside its wait state");

   // A new response appears only out of the posting state.
   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_POST))
      else $error("response raised without posting");

endmodule : markov_neighbour_count_sampler
`default_nettype wire

// ===== src/mnc_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mnc_decode
// Checks the offset and tile indexes of a request and forms the base
// address of the table row selected by offset and current tile.
// ----------------------------------------------------------------------------
module mnc_decode
   import mnc_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF,
   parameter int RADIUS    = RADIUS_DEF,
   parameter int ADDR_W    = 11
) (
   input  logic                       req_type,
   input  logic [REQ_W-1:0]           req_code,
   input  logic signed [OFFSET_W-1:0] offset_x,
   input  logic signed [OFFSET_W-1:0] offset_y,
   input  logic [TILE_W-1:0]          current_tile,
   input  logic [TILE_W-1:0]          other_tile,
   input  logic [CFG_W-1:0]           ntiles,
   output mnc_dec_type                dec,
   output logic [ADDR_W-1:0]          row_addr
);

   localparam int SIDE   = 2 * RADIUS + 1;
   localparam int POS_W  = $clog2(SIDE * SIDE);
   localparam int CENTRE = RADIUS * SIDE + RADIUS;

   logic [3:0]       bias_x;
   logic [3:0]       bias_y;
   logic             x_ok;
   logic             y_ok;
   logic             bad_offset;
   logic             bad_tile;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] off_idx;

   // Offsets moved into the range 0 .. 2*RADIUS; a set top bit means the
   // component was below -RADIUS.
   assign bias_x = {offset_x[OFFSET_W-1], offset_x} + 4'(RADIUS);
   assign bias_y = {offset_y[OFFSET_W-1], offset_y} + 4'(RADIUS);
   assign x_ok   = !bias_x[3] && (bias_x <= 4'(2 * RADIUS));
   assign y_ok   = !bias_y[3] && (bias_y <= 4'(2 * RADIUS));

   assign bad_offset = ((offset_x == '0) && (offset_y == '0)) || !x_ok || !y_ok;
   assign bad_tile   = ({1'b0, current_tile} >= ntiles) ||
                       ((req_code != REQ_SAMPLE) && ({1'b0, other_tile} >= ntiles));

   // Offset number with x outer and y inner, the centre position removed.
   assign pos     = POS_W'(bias_x[2:0]) * POS_W'(SIDE) + POS_W'(bias_y[2:0]);
   assign off_idx = (pos > POS_W'(CENTRE)) ? pos - 1'b1 : pos;

   assign row_addr = ADDR_W'(off_idx) * ADDR_W'(MAX_TILES * MAX_TILES) +
                     ADDR_W'(current_tile) * ADDR_W'(MAX_TILES);

   always_comb begin
      dec.run    = 1'b0;
      dec.status = ST_OK;
      if (!req_type || (req_code == REQ_IGNORE)) begin
         dec.status = ST_OK;
      end else if (bad_offset) begin
         dec.status = ST_BAD_OFFSET;
      end else if (bad_tile) begin
         dec.status = ST_BAD_TILE;
      end else begin
         dec.run = 1'b1;
      end
   end

endmodule : mnc_decode
`default_nettype wire

// ===== src/mnc_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mnc_mod_unit
// Restoring remainder unit: one dividend bit per cycle, done pulses
// with the remainder valid in the same cycle.
// ----------------------------------------------------------------------------
module mnc_mod_unit
   import mnc_pkg::*;
#(
   parameter int SUM_W = COUNT_WIDTH_DEF + TILE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RND_W-1:0] dividend,
   input  logic [SUM_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] remainder
);

   localparam int CNT_W = $clog2(RND_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0] dvd_ff, dvd_in;
   logic [SUM_W-1:0] dvs_ff, dvs_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[RND_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one compare
         // and subtract per bit is enough.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = SUM_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = SUM_W'(trial);
         end
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule : mnc_mod_unit
`default_nettype wire

// ===== sim/markov_neighbour_count_sampler_test.sv =====
// ----------------------------------------------------------------------------
// markov_neighbour_count_sampler_test
// Self-checking testbench for the neighbour transition count sampler. A
// scoreboard keeps its own copy of the count table and the tile setting,
// predicts the response of every accepted request transaction and compares
// it with the responses in order, while both channels idle at random.
// ----------------------------------------------------------------------------
module markov_neighbour_count_sampler_test;
   import mnc_pkg::*;

   // Geometry of the count table, derived from the block's default parameters.
   localparam int MAX_TILES      = MAX_TILES_DEF;
   localparam int RADIUS         = RADIUS_DEF;
   localparam int COUNT_WIDTH    = COUNT_WIDTH_DEF;
   localparam int SIDE           = 2 * RADIUS + 1;
   localparam int CENTRE         = RADIUS * SIDE + RADIUS;
   localparam int TABLE_DEPTH    = (SIDE * SIDE - 1) * MAX_TILES * MAX_TILES;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

   // The clearing pass after reset is the longest legal silence on both
   // channels, so the watchdog limit sits well above it.
   localparam int WATCHDOG_LIMIT = 10000;
   // Length of the gapless observe burst aimed at one table entry.
   localparam int BURST_REPEATS  = 40;
   localparam int DRAIN_CYCLES   = 100;

   // One request transaction and one response transaction, field by field.
   typedef struct packed {
      logic [REQ_W-1:0]           kind;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic [TILE_W-1:0]          current_tile;
      logic [TILE_W-1:0]          other_tile;
      logic [RND_W-1:0]           random_value;
   } request_type;

   typedef struct packed {
      logic [TILE_W-1:0]   tile;
      logic [OUT_W-1:0]    count;
      logic [STATUS_W-1:0] status;
   } response_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the count table, predicts each response when its
   // request is accepted and checks the responses in arrival order.
   // -------------------------------------------------------------------------
   class transition_scoreboard_type;
      int unsigned      counts[TABLE_DEPTH];
      logic [CFG_W-1:0] tiles_setting;
      response_type     pending_responses[$];
      int               mismatches;
      int               checked;
      int               kind_seen[4];
      int               status_seen[4];
      int               drawn_samples;
      int               saturated_hits;

      function new();
         foreach (counts[i]) counts[i] = 0;
         tiles_setting  = 5'd16;
         mismatches     = 0;
         checked        = 0;
         drawn_samples  = 0;
         saturated_hits = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_tiles(logic [CFG_W-1:0] value);
         tiles_setting = value;
      endfunction

      function bit idle();
         return pending_responses.size() == 0;
      endfunction

      function int failures();
         return mismatches + pending_responses.size();
      endfunction

      function logic [OUT_W-1:0] clip_count(longint unsigned value);
         return (value > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(value);
      endfunction

      // Applies one request to the mirrored table and returns its response.
      function response_type predict_transition(request_type q);
         response_type    res;
         int              ntiles;
         int              dx;
         int              dy;
         int              pos;
         int              slot;
         int              base;
         int              t;
         longint unsigned total;
         longint unsigned running;
         longint unsigned draw;
         res    = '0;
         ntiles = (tiles_setting > MAX_TILES) ? MAX_TILES : int'(tiles_setting);
         dx     = $signed(q.offset_x);
         dy     = $signed(q.offset_y);
         if (q.kind == REQ_IGNORE) return res;
         if ((dx == 0 && dy == 0) || dx < -RADIUS || dx > RADIUS ||
             dy < -RADIUS || dy > RADIUS) begin
            res.status = ST_BAD_OFFSET;
            return res;
         end
         if (int'(q.current_tile) >= ntiles ||
             (q.kind != REQ_SAMPLE && int'(q.other_tile) >= ntiles)) begin
            res.status = ST_BAD_TILE;
            return res;
         end
         // Offsets are numbered x outer, y inner, with the centre left out.
         pos  = (dx + RADIUS) * SIDE + (dy + RADIUS);
         slot = (pos > CENTRE) ? pos - 1 : pos;
         base = (slot * MAX_TILES + int'(q.current_tile)) * MAX_TILES;
         case (q.kind)
            REQ_OBSERVE: begin
               if (counts[base + q.other_tile] < COUNT_MAX)
                  counts[base + q.other_tile]++;
               res.count = clip_count(counts[base + q.other_tile]);
            end
            REQ_QUERY: begin
               res.count = clip_count(counts[base + q.other_tile]);
            end
            default: begin
               total = 0;
               for (t = 0; t < ntiles; t++) total += counts[base + t];
               if (total != 0) begin
                  draw    = longint'(q.random_value) % total;
                  running = 0;
                  for (t = 0; t < ntiles; t++) begin
                     running += counts[base + t];
                     if (running > draw) begin
                        res.tile = TILE_W'(t);
                        break;
                     end
                  end
               end
               res.count = clip_count(total);
            end
         endcase
         return res;
      endfunction

      function void note_request(request_type q);
         response_type exp;
         exp = predict_transition(q);
         kind_seen[q.kind]++;
         status_seen[exp.status]++;
         if (q.kind == REQ_SAMPLE && exp.status == ST_OK && exp.count != 0)
            drawn_samples++;
         if (exp.count == OUT_W'(OUT_MAX)) saturated_hits++;
         pending_responses = {pending_responses, exp};
      endfunction

      function void check_response(response_type got);
         response_type exp;
         checked++;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with nothing outstanding: %s",
                        $sformatf("tile %0d count %0d status %0d",
                                  got.tile, got.count, got.status));
            return;
         end
         exp = pending_responses.pop_front();
         if (got.tile !== exp.tile || got.count !== exp.count || got.status !== exp.status)
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %0d: expected tile %0d count %0d status %0d, %s",
                        checked, exp.tile, exp.count, exp.status,
                        $sformatf("got tile %0d count %0d status %0d",
                                  got.tile, got.count, got.status));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the block under test.
   // -------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write;
   logic [CFG_W-1:0]           csr_tiles_in_use;
   logic                       req_valid;
   logic                       req_stall;
   logic [REQ_W-1:0]           req_type;
   logic signed [OFFSET_W-1:0] req_offset_x;
   logic signed [OFFSET_W-1:0] req_offset_y;
   logic [TILE_W-1:0]          req_current_tile;
   logic [TILE_W-1:0]          req_other_tile;
   logic [RND_W-1:0]           req_random_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [TILE_W-1:0]          rsp_tile_out;
   logic [OUT_W-1:0]           rsp_count_out;
   logic [STATUS_W-1:0]        rsp_status;

   transition_scoreboard_type sb = new();

   // Fast mode turns off all idling on both sides for the gapless burst.
   bit fast_mode    = 1'b0;
   // Mirrors req_valid so that it is only lowered when it is actually high.
   bit valid_raised = 1'b0;
   int gapless_left = 0;
   int quiet_cycles = 0;

   markov_neighbour_count_sampler #(
      .MAX_TILES   (MAX_TILES),
      .RADIUS      (RADIUS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_tiles_in_use (csr_tiles_in_use),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_offset_x     (req_offset_x),
      .req_offset_y     (req_offset_y),
      .req_current_tile (req_current_tile),
      .req_other_tile   (req_other_tile),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tile_out     (rsp_tile_out),
      .rsp_count_out    (rsp_count_out),
      .rsp_status       (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Helpers.
   // -------------------------------------------------------------------------

   // Idle length in cycles: half the time none, mostly short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic request_type pack_request(logic [REQ_W-1:0] kind, int dx, int dy,
                                                int cur, int oth, logic [RND_W-1:0] rnd);
      request_type q;
      q.kind         = kind;
      q.offset_x     = OFFSET_W'(dx);
      q.offset_y     = OFFSET_W'(dy);
      q.current_tile = TILE_W'(cur);
      q.other_tile   = TILE_W'(oth);
      q.random_value = rnd;
      return q;
   endfunction

   // Builds one random request. Most are well formed and aimed at a few hot
   // rows, so that samples see rows with several populated tiles; the rest
   // carry bad offsets, out-of-range tiles or an unknown request code.
   function automatic request_type make_request(int ntiles);
      request_type q;
      int          roll;
      int          flavor;
      int          dx;
      int          dy;
      int          hot_limit;
      roll = $urandom_range(0, 99);
      q.kind = (roll < 45) ? REQ_OBSERVE :
               (roll < 65) ? REQ_QUERY   :
               (roll < 95) ? REQ_SAMPLE  : REQ_IGNORE;
      flavor = $urandom_range(0, 9);
      q.random_value = (flavor < 6) ? RND_W'($urandom) :
                       (flavor < 9) ? RND_W'($urandom_range(0, 40)) : '1;
      q.current_tile = TILE_W'($urandom);
      q.other_tile   = TILE_W'($urandom);
      q.offset_x     = OFFSET_W'($urandom);
      q.offset_y     = OFFSET_W'($urandom);
      flavor = $urandom_range(0, 99);
      if (q.kind == REQ_IGNORE) return q;
      if (flavor < 3) begin
         // The centre itself is not a neighbour.
         q.offset_x = '0;
         q.offset_y = '0;
      end else if (flavor < 6) begin
         // Horizontal component outside the window: codes 2, 3, -4, -3.
         q.offset_x = OFFSET_W'($urandom_range(2, 5));
      end else begin
         if ($urandom_range(0, 9) < 7) begin
            dx = ($urandom_range(0, 1) == 0) ? -1 : 1;
            dy = (dx < 0) ? 0 : 1;
         end else begin
            dx = int'($urandom_range(0, 2)) - 1;
            dy = int'($urandom_range(0, 2)) - 1;
            if (dx == 0 && dy == 0) dy = ($urandom_range(0, 1) == 0) ? -1 : 1;
         end
         q.offset_x = OFFSET_W'(dx);
         q.offset_y = OFFSET_W'(dy);
         // A small share keeps fully random tiles, which may be out of range.
         if (flavor >= 14 && ntiles > 0) begin
            hot_limit = (ntiles < 3) ? ntiles : 3;
            q.current_tile = ($urandom_range(0, 9) < 7) ?
                             TILE_W'($urandom_range(0, hot_limit - 1)) :
                             TILE_W'($urandom_range(0, ntiles - 1));
            q.other_tile   = TILE_W'($urandom_range(0, ntiles - 1));
         end
      end
      return q;
   endfunction

   // Presents one request transaction and returns at the falling edge after
   // it has been accepted. The valid stays high, so a following request with
   // no gap simply replaces the payload.
   task automatic send_request(input request_type q);
      int gap;
      if (fast_mode) begin
         gap = 0;
      end else if (gapless_left > 0) begin
         gap = 0;
         gapless_left--;
      end else begin
         gap = idle_length();
         if ($urandom_range(0, 99) == 0) gapless_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         if (valid_raised) begin
            req_valid    <= 1'b0;
            valid_raised  = 1'b0;
         end
         repeat (gap) @(negedge clock);
      end
      req_type         <= q.kind;
      req_offset_x     <= q.offset_x;
      req_offset_y     <= q.offset_y;
      req_current_tile <= q.current_tile;
      req_other_tile   <= q.other_tile;
      req_random_value <= q.random_value;
      req_valid        <= 1'b1;
      valid_raised      = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // Lowers the request valid and waits until every response has come back.
   task automatic wait_drained();
      if (valid_raised) begin
         req_valid    <= 1'b0;
         valid_raised  = 1'b0;
      end
      while (!sb.idle()) @(negedge clock);
   endtask

   // Called while the block is idle, and once straight after reset while it clears.
   task automatic write_tiles(input logic [CFG_W-1:0] value);
      csr_tiles_in_use <= value;
      csr_write        <= 1'b1;
      @(negedge clock);
      csr_write        <= 1'b0;
      sb.set_tiles(value);
   endtask

   // One phase of random traffic under one tile setting. Halfway through, the
   // sender holds off until every outstanding response has been returned.
   task automatic run_phase(input logic [CFG_W-1:0] setting, input int items);
      int ntiles;
      int i;
      wait_drained();
      write_tiles(setting);
      ntiles = (setting > MAX_TILES) ? MAX_TILES : int'(setting);
      for (i = 0; i < items; i++) begin
         if (i == items / 2) wait_drained();
         send_request(make_request(ntiles));
      end
   endtask

   // -------------------------------------------------------------------------
   // Response stall: random hold periods separated by open windows, with an
   // occasional long open window so that the block also runs unthrottled.
   // -------------------------------------------------------------------------
   initial begin
      int hold_cycles;
      int open_cycles;
      rsp_stall   = 1'b0;
      hold_cycles = 0;
      open_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0 && !fast_mode) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= 1'b0;
            if (open_cycles > 0) begin
               open_cycles--;
            end else begin
               hold_cycles = idle_length();
               open_cycles = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 200) :
                                                             $urandom_range(0, 6);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: both channels are sampled at the rising edge. The response is
   // checked before the request of the same edge is noted, which keeps the
   // expectation queue in order. The watchdog ends the run when neither
   // channel has moved a transaction for too long.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_response({rsp_tile_out, rsp_count_out, rsp_status});
      if (req_valid === 1'b1 && req_stall === 1'b0)
         sb.note_request({req_type, req_offset_x, req_offset_y, req_current_tile,
                          req_other_tile, req_random_value});
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction on either channel for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int dx;
      int dy;
      int i;
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_tiles_in_use = 5'd16;
      req_valid        = 1'b0;
      req_type         = REQ_OBSERVE;
      req_offset_x     = '0;
      req_offset_y     = '0;
      req_current_tile = '0;
      req_other_tile   = '0;
      req_random_value = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // The register is written straight after reset. The block then clears
      // its table and holds off requests, which the first send simply waits out.
      write_tiles(5'd16);

      // Directed transactions. A sample of a row that was never observed
      // returns tile 0 with a zero total.
      send_request(pack_request(REQ_SAMPLE, -1, -1, 0, 0, '1));
      // Build a small row at the lowest offset and read it back.
      send_request(pack_request(REQ_OBSERVE, -1, -1, 0, 15, '0));
      send_request(pack_request(REQ_OBSERVE, -1, -1, 0, 15, '0));
      send_request(pack_request(REQ_OBSERVE, -1, -1, 0, 3, '0));
      send_request(pack_request(REQ_QUERY, -1, -1, 0, 15, '0));
      send_request(pack_request(REQ_QUERY, 1, 1, 15, 0, '1));
      send_request(pack_request(REQ_OBSERVE, 1, 1, 15, 0, '1));
      // Draws at both ends of the random range over a populated row, and one mid-range draw over another.
      send_request(pack_request(REQ_SAMPLE, -1, -1, 0, 0, '0));
      send_request(pack_request(REQ_SAMPLE, -1, -1, 0, 15, '1));
      send_request(pack_request(REQ_SAMPLE, 1, 1, 15, 15, 31'd12345));
      // The centre and offsets outside the window are rejected for observe, query
      // and sample requests.
      send_request(pack_request(REQ_OBSERVE, 0, 0, 1, 1, '0));
      send_request(pack_request(REQ_QUERY, -4, 3, 0, 0, '0));
      send_request(pack_request(REQ_SAMPLE, 3, -4, 15, 15, '1));
      send_request(pack_request(REQ_OBSERVE, 2, 0, 0, 0, '0));
      send_request(pack_request(REQ_QUERY, 0, -2, 0, 0, '0));
      // The unknown request code is answered with zeros whatever it carries.
      send_request(pack_request(REQ_IGNORE, -1, -1, 15, 15, '1));
      send_request(pack_request(REQ_IGNORE, 0, 0, 0, 0, '0));
      // One observe at every valid offset, which checks the offset numbering.
      for (dx = -RADIUS; dx <= RADIUS; dx++)
         for (dy = -RADIUS; dy <= RADIUS; dy++)
            if (dx != 0 || dy != 0)
               send_request(pack_request(REQ_OBSERVE, dx, dy, 15, 15, '0));

      // Gapless burst: one count is built up back to back, then a neighbour in
      // the same row joins it and the row is queried and sampled.
      wait_drained();
      fast_mode = 1'b1;
      for (i = 0; i < BURST_REPEATS; i++)
         send_request(pack_request(REQ_OBSERVE, 1, 0, 2, 7, '0));
      send_request(pack_request(REQ_OBSERVE, 1, 0, 2, 8, '0));
      send_request(pack_request(REQ_OBSERVE, 1, 0, 2, 8, '0));
      send_request(pack_request(REQ_QUERY, 1, 0, 2, 7, '0));
      send_request(pack_request(REQ_SAMPLE, 1, 0, 2, 0, '1));
      send_request(pack_request(REQ_SAMPLE, 1, 0, 2, 0, 31'd65535));
      send_request(pack_request(REQ_SAMPLE, 1, 0, 2, 0, 31'd65536));
      send_request(pack_request(REQ_SAMPLE, 1, 0, 2, 0, RND_W'($urandom)));
      wait_drained();
      fast_mode = 1'b0;

      // Random traffic under several tile settings: a mid value, a single
      // tile, no tiles at all, the all-ones code that acts as the maximum,
      // another mid value and the maximum itself.
      run_phase(5'd5, 220);
      run_phase(5'd1, 120);
      run_phase(5'd0, 40);
      run_phase(5'd31, 300);
      run_phase(5'd12, 250);
      run_phase(5'd16, 300);

      wait_drained();
      // Any response arriving now has no request behind it and is flagged.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Coverage: %0d observe, %0d query, %0d sample (%0d drawn), %0d unknown.",
               sb.kind_seen[REQ_OBSERVE], sb.kind_seen[REQ_QUERY],
               sb.kind_seen[REQ_SAMPLE], sb.drawn_samples, sb.kind_seen[REQ_IGNORE]);
      $display("Checked %0d responses: %0d bad offset, %0d bad tile, %0d at ceiling, %s",
               sb.checked, sb.status_seen[ST_BAD_OFFSET], sb.status_seen[ST_BAD_TILE],
               sb.saturated_hits, $sformatf("%0d mismatched.", sb.failures()));
      if (sb.failures() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule : markov_neighbour_count_sampler_test
